// File: src/wms_pkg.sv
package wms_pkg;

    // Fixed field widths
    localparam int SUM_BITS = 24;
    localparam int LEN_BITS = 9;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 9'd1;

    // Result queue
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_LONG = 2'd1,
        STATUS_ZERO     = 2'd2
    } t_status;

    typedef struct packed {
        logic [SUM_BITS-1:0] max_sum;
        t_status             status;
    } t_result;

endpackage

// File: src/window_max_sum_core.sv
// window_max_sum_core: largest sum over any run of window_length consecutive
// samples of an array.
//
// Input channel (i_valid/o_ready): one signed sample per transfer, with
// i_last_sample marking the final element of an array. One sample per cycle
// is sustained while o_ready is high; the running window sum is one add and
// one subtract against the leaving sample, read from the window RAM in stage 0.
// Output channel (o_valid/i_ready): one result per array, carrying the best
// full-window sum and a status (ok, window longer than data, window zero).
// Each result passes the stage 1 and stage 2 registers before it is queued.
// Results wait in a 4-entry queue; o_ready drops only when the queue plus the
// last-sample transfers still in the pipe would fill it, so a stalled
// receiver holds back input only after several arrays have completed.
// Configuration (i_cfg_valid/o_cfg_ready): writes window_length, always
// ready; write only while the block is idle. Reset value of the length is 1.
// Reset clears the pipe, counters and result queue; the window RAM needs no
// clearing, as an entry is only read once it has been written.
module window_max_sum_core #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wms_pkg::LEN_BITS-1:0]     i_cfg_data,
    // sample input
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  logic                             i_last_sample,
    // result output
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [wms_pkg::SUM_BITS-1:0] o_max_sum,
    output wms_pkg::t_status                 o_status
);

    import wms_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int XW = ((CW > LEN_BITS) ? CW : LEN_BITS) + 1;
    localparam int SW = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [LEN_BITS-1:0] r_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_valid) begin
            r_len <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: ring position, fill count, RAM write and read issue
    // ---------------------------------------------------------------
    logic          in_fire;
    logic          active;
    logic [AW-1:0] r_wp;
    logic [CW-1:0] r_seen;
    logic [CW-1:0] seen_inc;
    logic [XW-1:0] wp_x;
    logic [XW-1:0] len_x;
    logic [XW-1:0] back_x;
    logic [AW-1:0] rd_addr;
    logic          sub_old;
    logic          full_now;
    logic signed [SW-1:0] sample_ext;

    assign in_fire = i_valid && o_ready;
    assign active  = (r_len != '0);

    assign wp_x   = XW'(r_wp);
    assign len_x  = XW'(r_len);
    // Slot of the sample leaving the window; only used once the window is full
    assign back_x = (wp_x >= len_x) ? (wp_x - len_x)
                                    : (wp_x + XW'(WINDOW_MAX) - len_x);
    assign rd_addr = back_x[AW-1:0];

    assign seen_inc = (r_seen == CW'(WINDOW_MAX)) ? r_seen : (r_seen + CW'(1));
    assign sub_old  = (XW'(r_seen) >= len_x);
    assign full_now = (XW'(seen_inc) >= len_x);

    assign sample_ext = SW'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_seen <= '0;
        end else if (in_fire) begin
            if (i_last_sample) begin
                r_wp   <= '0;
                r_seen <= '0;
            end else if (active) begin
                r_wp   <= (r_wp == AW'(WINDOW_MAX - 1)) ? '0 : (r_wp + AW'(1));
                r_seen <= seen_inc;
            end
        end
    end

    logic [SAMPLE_BITS-1:0] ram_rd_data;

    wms_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_fire && active),
        .i_wr_addr (r_wp),
        .i_wr_data (i_sample),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Stage 1 pipe registers
    logic                r_s1_valid;
    logic                r_s1_active;
    logic                r_s1_sub;
    logic                r_s1_full;
    logic                r_s1_last;
    logic [SUM_BITS-1:0] r_s1_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_fire;
        end
        r_s1_active <= active;
        r_s1_sub    <= sub_old;
        r_s1_full   <= full_now;
        r_s1_last   <= i_last_sample;
        r_s1_sample <= sample_ext[SUM_BITS-1:0];
    end

    // ---------------------------------------------------------------
    // Stage 1: running window sum
    // ---------------------------------------------------------------
    logic                 r_rs_fresh;  // next sample starts a new array
    logic [SUM_BITS-1:0]  r_rs;
    logic [SUM_BITS-1:0]  rs_base;
    logic [SUM_BITS-1:0]  old_val;
    logic [SUM_BITS-1:0]  n_rs;
    logic signed [SW-1:0] old_ext;

    assign old_ext = SW'($signed(ram_rd_data));
    assign old_val = r_s1_sub ? old_ext[SUM_BITS-1:0] : '0;
    assign rs_base = r_rs_fresh ? '0 : r_rs;
    assign n_rs    = rs_base + r_s1_sample - old_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_fresh <= 1'b1;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_rs_fresh <= 1'b1;
            end else if (r_s1_active) begin
                r_rs_fresh <= 1'b0;
            end
        end
        if (r_s1_valid && r_s1_active) begin
            r_rs <= n_rs;
        end
    end

    // Stage 2 pipe registers
    logic                r_s2_valid;
    logic                r_s2_active;
    logic                r_s2_full;
    logic                r_s2_last;
    logic [SUM_BITS-1:0] r_s2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_active <= r_s1_active;
        r_s2_full   <= r_s1_full;
        r_s2_last   <= r_s1_last;
        r_s2_sum    <= r_s1_active ? n_rs : rs_base;
    end

    // ---------------------------------------------------------------
    // Stage 2: best full-window sum and result build
    // ---------------------------------------------------------------
    logic                r_bv_fresh;
    logic                r_bv;
    logic [SUM_BITS-1:0] r_best;
    logic                bv_eff;
    logic                take_new;
    logic [SUM_BITS-1:0] best_next;
    logic                push;
    t_result             result;

    assign bv_eff    = r_bv_fresh ? 1'b0 : r_bv;
    assign take_new  = !bv_eff || ($signed(r_s2_sum) > $signed(r_best));
    assign best_next = take_new ? r_s2_sum : r_best;
    assign push      = r_s2_valid && r_s2_last;

    always_comb begin
        result.max_sum = '0;
        result.status  = STATUS_OK;
        if (!r_s2_active) begin
            result.status = STATUS_ZERO;
        end else if (r_s2_full) begin
            result.max_sum = best_next;
        end else if (bv_eff) begin
            result.max_sum = r_best;
        end else begin
            result.status = STATUS_TOO_LONG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv_fresh <= 1'b1;
            r_bv       <= 1'b0;
        end else if (r_s2_valid) begin
            if (r_s2_last) begin
                r_bv_fresh <= 1'b1;
            end else if (r_s2_active && r_s2_full) begin
                r_bv_fresh <= 1'b0;
                r_bv       <= 1'b1;
            end
        end
        if (r_s2_valid && !r_s2_last && r_s2_active && r_s2_full) begin
            r_best <= best_next;
        end
    end

    // ---------------------------------------------------------------
    // Result queue with credit check on the input side
    // ---------------------------------------------------------------
    t_result              r_q [QDEPTH];
    logic [QPTR_BITS-1:0] r_q_wr;
    logic [QPTR_BITS-1:0] r_q_rd;
    logic [QCNT_BITS-1:0] r_q_count;
    logic                 pop;
    logic [QCNT_BITS:0]   committed;

    // Results queued plus last-sample transfers still in the pipe
    assign committed = (QCNT_BITS + 1)'(r_q_count)
                     + (QCNT_BITS + 1)'(r_s1_valid && r_s1_last)
                     + (QCNT_BITS + 1)'(r_s2_valid && r_s2_last);
    assign o_ready   = (committed < (QCNT_BITS + 1)'(QDEPTH));

    assign o_valid   = (r_q_count != '0);
    assign pop       = o_valid && i_ready;
    assign o_max_sum = $signed(r_q[r_q_rd].max_sum);
    assign o_status  = r_q[r_q_rd].status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= '0;
            r_q_rd    <= '0;
            r_q_count <= '0;
        end else begin
            if (push) begin
                r_q_wr <= r_q_wr + QPTR_BITS'(1);
            end
            if (pop) begin
                r_q_rd <= r_q_rd + QPTR_BITS'(1);
            end
            if (push && !pop) begin
                r_q_count <= r_q_count + QCNT_BITS'(1);
            end else if (pop && !push) begin
                r_q_count <= r_q_count - QCNT_BITS'(1);
            end
        end
        if (push) begin
            r_q[r_q_wr] <= result;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !pop && (r_q_count == QCNT_BITS'(QDEPTH))))
        else $error("result queue overflow");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        committed <= (QCNT_BITS + 1)'(QDEPTH))
        else $error("more results committed than queue space");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STATUS_OK)) |-> (o_max_sum == '0))
        else $error("non-zero sum with error status");

    a_last_reaches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_last_sample) |=> ##1 push)
        else $error("last-sample transfer did not produce a result");

endmodule

// File: src/wms_ram.sv
module wms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read-first: a read of the entry being written returns the old data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// File: tb/window_max_sum_checker.sv
// Watches the configuration, sample and result channels of the core,
// predicts the best window sum of each array and compares every result.
module window_max_sum_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [wms_pkg::LEN_BITS-1:0]        i_cfg_data,
    input  logic                                i_valid,
    input  logic                                i_ready,
    input  logic signed [15:0]                  i_sample,
    input  logic                                i_last_sample,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic signed [wms_pkg::SUM_BITS-1:0] i_max_sum,
    input  wms_pkg::t_status                    i_status,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import wms_pkg::*;

    localparam int RING_DEPTH = 256;

    // predictor state
    logic [LEN_BITS-1:0]        win_len;
    logic signed [15:0]         recent_samples [0:RING_DEPTH-1];
    logic [7:0]                 wr_pos;
    logic signed [SUM_BITS-1:0] window_sum;
    logic signed [SUM_BITS-1:0] best_window;
    logic [8:0]                 seen;
    logic                       best_ok;

    t_result predicted_sums [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_fail_count < 40)
            $display("ERROR at %0t ns: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic clear_array();
        wr_pos      = '0;
        window_sum  = '0;
        best_window = '0;
        seen        = '0;
        best_ok     = 1'b0;
    endtask

    // one sample through the running window; pushes a result on the last one
    task automatic absorb_sample(input logic signed [15:0] smp, input logic last);
        logic [7:0] old_idx;
        t_result    r;
        if (win_len != '0) begin
            if (seen >= win_len) begin
                old_idx    = wr_pos - win_len[7:0];
                window_sum = window_sum + smp - recent_samples[old_idx];
            end else begin
                window_sum = window_sum + smp;
            end
            recent_samples[wr_pos] = smp;
            wr_pos = wr_pos + 8'd1;
            if (seen < 9'd256)
                seen = seen + 9'd1;
            if (seen >= win_len) begin
                if (!best_ok || window_sum > best_window)
                    best_window = window_sum;
                best_ok = 1'b1;
            end
        end
        if (last) begin
            if (win_len == '0) begin
                r.max_sum = '0;
                r.status  = STATUS_ZERO;
            end else if (!best_ok) begin
                r.max_sum = '0;
                r.status  = STATUS_TOO_LONG;
            end else begin
                r.max_sum = best_window;
                r.status  = STATUS_OK;
            end
            predicted_sums.push_back(r);
            clear_array();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            win_len = LEN_RESET;
            clear_array();
            predicted_sums.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                win_len = i_cfg_data;
            if (i_valid && i_ready)
                absorb_sample(i_sample, i_last_sample);
            if (i_res_valid && i_res_ready) begin
                o_results++;
                if (predicted_sums.size() == 0) begin
                    report_mismatch($sformatf("result with none due: sum %0d status %0d",
                                              i_max_sum, i_status));
                end else begin
                    want = predicted_sums.pop_front();
                    if (i_max_sum !== want.max_sum)
                        report_mismatch($sformatf("max_sum %0d, wanted %0d", i_max_sum,
                                                  $signed(want.max_sum)));
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d", i_status,
                                                  want.status));
                end
            end
        end
        o_pending = predicted_sums.size();
    end

endmodule

// File: tb/testbench.sv
// Stimulus and verdict for window_max_sum_core. The checker alongside the
// core does all prediction and comparison; this module only drives the
// three channels and decides pass or fail from the checker's count.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wms_pkg::*;

    // all inputs known from time zero
    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_valid   = 1'b0;
    logic [LEN_BITS-1:0]        i_cfg_data    = '0;
    logic                       i_valid       = 1'b0;
    logic signed [15:0]         i_sample      = '0;
    logic                       i_last_sample = 1'b0;
    logic                       i_ready       = 1'b0;
    logic                       o_cfg_ready;
    logic                       o_ready;
    logic                       o_valid;
    logic signed [SUM_BITS-1:0] o_max_sum;
    t_status                    o_status;

    int fail_count;
    int pending;
    int results;

    // bookkeeping for the summary
    int samples_sent = 0;
    int arrays_sent  = 0;
    int settings     = 0;

    // receiver hold-off request, raised once by the stimulus
    bit hold_req  = 1'b0;
    bit hold_on   = 1'b0;
    bit hold_done = 1'b0;
    localparam int HOLD_CYCLES = 300;

    window_max_sum_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_max_sum     (o_max_sum),
        .o_status      (o_status)
    );

    window_max_sum_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_ready       (o_ready),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_max_sum     (o_max_sum),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle stretch length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Sample content: extremes, small values around zero, or full range.
    // Mode 0 pins every sample at the top, mode 1 at the bottom, so that
    // window sums reach the bottom of the 24-bit range and near its top with a long window.
    function automatic logic [15:0] pick_sample(input int mode);
        int r;
        if (mode == 0)
            return 16'h7fff;
        if (mode == 1)
            return 16'h8000;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // One sample transfer. A gap lowers valid first; otherwise valid stays
    // high straight on from the previous transfer, so only one update per edge.
    task automatic send_sample(input logic [15:0] smp, input logic last, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= smp;
        i_last_sample <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        samples_sent++;
        if (last)
            arrays_sent++;
    endtask

    task automatic send_array(input int n, input int mode, input bit no_gaps);
        for (int i = 0; i < n; i++)
            send_sample(pick_sample(mode), i == n - 1, no_gaps);
    endtask

    // Stop offering, let every predicted result drain, then wait further
    // for anything still in the pipe.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Window length changes only with the core idle.
    task automatic set_length(input int len);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= LEN_BITS'(len);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // Receiver: alternating ready/idle stretches, with one long hold-off on
    // request so that the result queue fills and the input backs up.
    initial begin
        int on_len;
        int off_len;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                hold_on = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                on_len  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(1, 8);
                off_len = idle_len();
                i_ready <= 1'b1;
                repeat (on_len) @(posedge i_clk);
                if (off_len > 0) begin
                    i_ready <= 1'b0;
                    repeat (off_len) @(posedge i_clk);
                end
            end
        end
    end

    // Main stimulus
    initial begin
        int cur_len;
        int n_arrays;
        int n;
        int mode;
        int phase;
        bit squeezed;
        phase    = 0;
        squeezed = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset length of one, extremes and a single-sample array
        settings++;
        send_sample(16'h7fff, 1'b1, 1'b0);
        send_sample(16'h8000, 1'b1, 1'b0);
        send_sample(16'h0000, 1'b0, 1'b0);
        send_sample(16'hffff, 1'b0, 1'b0);
        send_sample(16'h0001, 1'b1, 1'b0);

        // Zero window: samples ignored, status says zero
        set_length(0);
        send_sample(16'h0005, 1'b0, 1'b0);
        send_sample(16'h7fff, 1'b1, 1'b0);
        send_sample(16'hffff, 1'b1, 1'b1);

        // Window of four: too few samples, then an exact all-minimum window
        set_length(4);
        send_sample(16'h0001, 1'b0, 1'b0);
        send_sample(16'h0002, 1'b0, 1'b0);
        send_sample(16'h0003, 1'b1, 1'b0);
        repeat (3) send_sample(16'h8000, 1'b0, 1'b1);
        send_sample(16'h8000, 1'b1, 1'b1);

        // Longest register value: can never fill
        set_length(511);
        send_sample(16'h0007, 1'b0, 1'b0);
        send_sample(16'h0009, 1'b1, 1'b0);

        // Random phases: the extremes first, then mostly short windows
        while (samples_sent < 1000) begin
            if (!squeezed && samples_sent >= 400) begin
                // back-pressure: short arrays flood the result queue while
                // the receiver holds off
                set_length(1);
                hold_req = 1'b1;
                wait (hold_on);
                for (int i = 0; i < 24; i++)
                    send_sample(pick_sample(2), 1'b1, 1'b1);
                squeezed = 1'b1;
            end

            case (phase)
                0: cur_len = 256;
                1: cur_len = 511;
                2: cur_len = 1;
                3: cur_len = 0;
                4: cur_len = 2;
                default: begin
                    case ($urandom_range(0, 11))
                        0:       cur_len = 0;
                        1:       cur_len = 1;
                        2:       cur_len = 256;
                        3:       cur_len = $urandom_range(257, 511);
                        4:       cur_len = $urandom_range(17, 64);
                        default: cur_len = $urandom_range(2, 16);
                    endcase
                end
            endcase
            phase++;
            set_length(cur_len);

            n_arrays = (cur_len >= 200 && cur_len <= 256) ? 2 : $urandom_range(3, 8);
            for (int a = 0; a < n_arrays; a++) begin
                if (cur_len == 0 || cur_len > 256) begin
                    // long arrays now and then, so the sample count saturates
                    if (cur_len > 256 && $urandom_range(0, 7) == 0)
                        n = $urandom_range(250, 270);
                    else
                        n = $urandom_range(1, 12);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       n = (cur_len > 1) ? cur_len - 1 : 1;
                        1:       n = cur_len;
                        2:       n = cur_len + $urandom_range(1, 20);
                        default: n = $urandom_range(1, cur_len + 8);
                    endcase
                end
                mode = $urandom_range(0, 9);
                if (mode > 2)
                    mode = 2;
                send_array(n, mode, $urandom_range(0, 3) == 0);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d samples in %0d arrays over %0d window settings,",
                 samples_sent, arrays_sent, settings);
        $display("with %0d results checked and one long receiver hold-off.", results);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
